// File: hw/rtl/ppit_pkg.sv
// ----------------------------------------------------------------------------
// ppit_pkg
// Shared types and constants of the polyline pair intersection test: the
// controller states, the product operation codes and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ppit_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_DIFF,
        ST_ISSUE,
        ST_DRAIN,
        ST_DECIDE,
        ST_REPORT
    } state_t;

    // one product term per operation; X = cross, D = dot along a-b, D2 = dot along p-q
    typedef enum logic [3:0] {
        OP_X_PA,
        OP_X_QA,
        OP_X_AP,
        OP_X_BP,
        OP_X_PAR,
        OP_D_PA,
        OP_D_QA,
        OP_D_BP,
        OP_D_BQ,
        OP_D2_AP,
        OP_D2_BP,
        OP_D2_QA,
        OP_D2_QB
    } op_t;

    localparam int NUM_OPS = 13;

    typedef struct packed {
        logic store_pt;
        logic eval_init;
        logic rd;
        logic diff;
        logic issue;
        op_t  op;
        logic advance;
        logic set_hit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic has_pairs;
        logic last_pair;
        logic meet;
    } status_t;

endpackage

// File: hw/rtl/ppit_point_store.sv
// ----------------------------------------------------------------------------
// ppit_point_store
// Point memory of one polyline: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ppit_point_store #(
    parameter int DEPTH = ppit_pkg::MAX_POINTS_DEF,
    parameter int WIDTH = 2 * ppit_pkg::COORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// File: hw/rtl/ppit_datapath.sv
// ----------------------------------------------------------------------------
// ppit_datapath
// Point stores, counts, pair indexes, difference vectors, the two-multiplier
// product unit and the segment meet decision.
// ----------------------------------------------------------------------------
module ppit_datapath #(
    parameter int MAX_POINTS = ppit_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = ppit_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ppit_pkg::cmd_t               cmd,
    output ppit_pkg::status_t            status,
    input  logic                         kind,
    input  logic signed [COORD_BITS-1:0] x_coord,
    input  logic signed [COORD_BITS-1:0] y_coord,
    output logic                         intersects,
    output logic                         overflow
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PTW = 2 * COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic [CW-1:0] fc_reg, fc_next;
    logic [CW-1:0] sc_reg, sc_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] k_reg, k_next;
    logic          dropped_reg, dropped_next;
    logic          hit_reg, hit_next;

    logic f_full, s_full, we_f, we_s, k_end;
    logic [PTW-1:0] wdata;
    logic [PTW-1:0] fa, fb, sp, sq;

    assign f_full = (fc_reg == CW'(MAX_POINTS));
    assign s_full = (sc_reg == CW'(MAX_POINTS));
    assign we_f   = cmd.store_pt && !kind && !f_full;
    assign we_s   = cmd.store_pt && kind && !s_full;
    assign wdata  = {x_coord, y_coord};
    assign k_end  = ((CW'(k_reg) + CW'(2)) == sc_reg);

    ppit_point_store #(.DEPTH(MAX_POINTS), .WIDTH(PTW)) u_first_store (
        .clk    (clk),
        .we     (we_f),
        .waddr  (fc_reg[AW-1:0]),
        .wdata  (wdata),
        .re     (cmd.rd),
        .raddr0 (i_reg),
        .raddr1 (i_reg + AW'(1)),
        .rdata0 (fa),
        .rdata1 (fb)
    );

    ppit_point_store #(.DEPTH(MAX_POINTS), .WIDTH(PTW)) u_second_store (
        .clk    (clk),
        .we     (we_s),
        .waddr  (sc_reg[AW-1:0]),
        .wdata  (wdata),
        .re     (cmd.rd),
        .raddr0 (k_reg),
        .raddr1 (k_reg + AW'(1)),
        .rdata0 (sp),
        .rdata1 (sq)
    );

    // counts, drop flag, pair indexes and the hit flag
    always_comb
    begin
        fc_next      = fc_reg;
        sc_next      = sc_reg;
        dropped_next = dropped_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        hit_next     = hit_reg;
        if (cmd.store_pt)
        begin
            if (we_f)
            begin
                fc_next = fc_reg + CW'(1);
            end
            if (we_s)
            begin
                sc_next = sc_reg + CW'(1);
            end
            if ((!kind && f_full) || (kind && s_full))
            begin
                dropped_next = 1'b1;
            end
        end
        if (cmd.eval_init)
        begin
            i_next   = '0;
            k_next   = '0;
            hit_next = 1'b0;
        end
        if (cmd.advance)
        begin
            if (k_end)
            begin
                k_next = '0;
                i_next = i_reg + AW'(1);
            end
            else
            begin
                k_next = k_reg + AW'(1);
            end
        end
        if (cmd.set_hit)
        begin
            hit_next = 1'b1;
        end
        if (cmd.clear)
        begin
            fc_next      = '0;
            sc_next      = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg      <= '0;
            sc_reg      <= '0;
            dropped_reg <= 1'b0;
            i_reg       <= '0;
            k_reg       <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            fc_reg      <= fc_next;
            sc_reg      <= sc_next;
            dropped_reg <= dropped_next;
            i_reg       <= i_next;
            k_reg       <= k_next;
            hit_reg     <= hit_next;
        end
    end

    // endpoints, sign extended to difference width
    logic signed [DW-1:0] ax, ay, bx, by, px, py, qx, qy;

    assign ax = DW'($signed(fa[PTW-1:COORD_BITS]));
    assign ay = DW'($signed(fa[COORD_BITS-1:0]));
    assign bx = DW'($signed(fb[PTW-1:COORD_BITS]));
    assign by = DW'($signed(fb[COORD_BITS-1:0]));
    assign px = DW'($signed(sp[PTW-1:COORD_BITS]));
    assign py = DW'($signed(sp[COORD_BITS-1:0]));
    assign qx = DW'($signed(sq[PTW-1:COORD_BITS]));
    assign qy = DW'($signed(sq[COORD_BITS-1:0]));

    logic signed [DW-1:0] dab_x_reg, dab_y_reg, dpq_x_reg, dpq_y_reg;
    logic signed [DW-1:0] pa_x_reg, pa_y_reg, qa_x_reg, qa_y_reg;
    logic signed [DW-1:0] ap_x_reg, ap_y_reg, bp_x_reg, bp_y_reg;
    logic signed [DW-1:0] bq_x_reg, bq_y_reg, qb_x_reg, qb_y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            dab_x_reg <= bx - ax;
            dab_y_reg <= by - ay;
            dpq_x_reg <= qx - px;
            dpq_y_reg <= qy - py;
            pa_x_reg  <= px - ax;
            pa_y_reg  <= py - ay;
            qa_x_reg  <= qx - ax;
            qa_y_reg  <= qy - ay;
            ap_x_reg  <= ax - px;
            ap_y_reg  <= ay - py;
            bp_x_reg  <= bx - px;
            bp_y_reg  <= by - py;
            bq_x_reg  <= bx - qx;
            bq_y_reg  <= by - qy;
            qb_x_reg  <= qx - bx;
            qb_y_reg  <= qy - by;
        end
    end

    // operand selection for one product term
    logic signed [DW-1:0] ux, uy, vx, vy;
    logic                 is_cross;

    always_comb
    begin
        ux       = dab_x_reg;
        uy       = dab_y_reg;
        vx       = pa_x_reg;
        vy       = pa_y_reg;
        is_cross = 1'b0;
        case (cmd.op)
            ppit_pkg::OP_X_PA:
            begin
                is_cross = 1'b1;
            end
            ppit_pkg::OP_X_QA:
            begin
                vx       = qa_x_reg;
                vy       = qa_y_reg;
                is_cross = 1'b1;
            end
            ppit_pkg::OP_X_AP:
            begin
                ux       = dpq_x_reg;
                uy       = dpq_y_reg;
                vx       = ap_x_reg;
                vy       = ap_y_reg;
                is_cross = 1'b1;
            end
            ppit_pkg::OP_X_BP:
            begin
                ux       = dpq_x_reg;
                uy       = dpq_y_reg;
                vx       = bp_x_reg;
                vy       = bp_y_reg;
                is_cross = 1'b1;
            end
            ppit_pkg::OP_X_PAR:
            begin
                vx       = dpq_x_reg;
                vy       = dpq_y_reg;
                is_cross = 1'b1;
            end
            ppit_pkg::OP_D_PA:
            begin
                is_cross = 1'b0;
            end
            ppit_pkg::OP_D_QA:
            begin
                vx = qa_x_reg;
                vy = qa_y_reg;
            end
            ppit_pkg::OP_D_BP:
            begin
                vx = bp_x_reg;
                vy = bp_y_reg;
            end
            ppit_pkg::OP_D_BQ:
            begin
                vx = bq_x_reg;
                vy = bq_y_reg;
            end
            ppit_pkg::OP_D2_AP:
            begin
                ux = dpq_x_reg;
                uy = dpq_y_reg;
                vx = ap_x_reg;
                vy = ap_y_reg;
            end
            ppit_pkg::OP_D2_BP:
            begin
                ux = dpq_x_reg;
                uy = dpq_y_reg;
                vx = bp_x_reg;
                vy = bp_y_reg;
            end
            ppit_pkg::OP_D2_QA:
            begin
                ux = dpq_x_reg;
                uy = dpq_y_reg;
                vx = qa_x_reg;
                vy = qa_y_reg;
            end
            ppit_pkg::OP_D2_QB:
            begin
                ux = dpq_x_reg;
                uy = dpq_y_reg;
                vx = qb_x_reg;
                vy = qb_y_reg;
            end
            default:
            begin
                is_cross = 1'b0;
            end
        endcase
    end

    // cross: ux*vy - vx*uy, dot: ux*vx + uy*vy
    logic signed [DW-1:0] m0_b, m1_a, m1_b;
    logic signed [PW-1:0] m0, m1;

    assign m0_b = is_cross ? vy : vx;
    assign m1_a = is_cross ? vx : uy;
    assign m1_b = is_cross ? uy : vy;
    assign m0   = PW'(ux) * PW'(m0_b);
    assign m1   = PW'(m1_a) * PW'(m1_b);

    logic signed [PW-1:0] prod0_reg, prod1_reg;
    logic                 cross1_reg;
    ppit_pkg::op_t        tag1_reg;
    logic                 v1_reg;

    always_ff @(posedge clk)
    begin
        prod0_reg  <= m0;
        prod1_reg  <= m1;
        cross1_reg <= is_cross;
        tag1_reg   <= cmd.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
        end
    end

    logic signed [SW-1:0] sum;
    logic                 zero_reg [ppit_pkg::NUM_OPS];
    logic                 neg_reg  [ppit_pkg::NUM_OPS];

    assign sum = cross1_reg ? (SW'(prod0_reg) - SW'(prod1_reg))
                            : (SW'(prod0_reg) + SW'(prod1_reg));

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            zero_reg[tag1_reg] <= (sum == '0);
            neg_reg[tag1_reg]  <= sum[SW-1];
        end
    end

    // segment meet decision from the stored signs
    logic zp, np, pp, zq, nq, pq, za, na, pa, zb, nb, pb;
    logic str1, str2, par0, ab_pt, pq_pt, a_eq_p, apart_ab, apart_pq;
    logic meet;

    always_comb
    begin
        zp = zero_reg[ppit_pkg::OP_X_PA];
        np = neg_reg[ppit_pkg::OP_X_PA];
        pp = !zp && !np;
        zq = zero_reg[ppit_pkg::OP_X_QA];
        nq = neg_reg[ppit_pkg::OP_X_QA];
        pq = !zq && !nq;
        za = zero_reg[ppit_pkg::OP_X_AP];
        na = neg_reg[ppit_pkg::OP_X_AP];
        pa = !za && !na;
        zb = zero_reg[ppit_pkg::OP_X_BP];
        nb = neg_reg[ppit_pkg::OP_X_BP];
        pb = !zb && !nb;
        str1 = zp || zq || (np && pq) || (nq && pp);
        str2 = za || zb || (na && pb) || (nb && pa);
        par0 = zero_reg[ppit_pkg::OP_X_PAR];
        ab_pt  = (dab_x_reg == '0) && (dab_y_reg == '0);
        pq_pt  = (dpq_x_reg == '0) && (dpq_y_reg == '0);
        a_eq_p = (pa_x_reg == '0) && (pa_y_reg == '0);
        apart_ab = (neg_reg[ppit_pkg::OP_D_PA] && neg_reg[ppit_pkg::OP_D_QA])
                || (neg_reg[ppit_pkg::OP_D_BP] && neg_reg[ppit_pkg::OP_D_BQ]);
        apart_pq = (neg_reg[ppit_pkg::OP_D2_AP] && neg_reg[ppit_pkg::OP_D2_BP])
                || (neg_reg[ppit_pkg::OP_D2_QA] && neg_reg[ppit_pkg::OP_D2_QB]);
        if (!str1 || !str2)
        begin
            meet = 1'b0;
        end
        else if (!par0)
        begin
            meet = 1'b1;
        end
        else if (!ab_pt)
        begin
            meet = !apart_ab;
        end
        else if (!pq_pt)
        begin
            meet = !apart_pq;
        end
        else
        begin
            meet = a_eq_p;
        end
    end

    assign status.meet      = meet;
    assign status.has_pairs = (fc_reg >= CW'(2)) && (sc_reg >= CW'(2));
    assign status.last_pair = k_end && ((CW'(i_reg) + CW'(2)) == fc_reg);

    assign intersects = hit_reg;
    assign overflow   = dropped_reg;

endmodule

// File: hw/rtl/ppit_ctrl.sv
// ----------------------------------------------------------------------------
// ppit_ctrl
// Controller: takes points, walks segment pairs through read, difference,
// product issue and decision until a pair meets, and strobes the result.
// ----------------------------------------------------------------------------
module ppit_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              kind,
    input  logic              last_point,
    input  ppit_pkg::status_t status,
    output logic              busy,
    output logic              done,
    output ppit_pkg::cmd_t    cmd
);

    ppit_pkg::state_t state_reg, state_next;
    ppit_pkg::op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppit_pkg::ST_IDLE;
            op_reg    <= ppit_pkg::OP_X_PA;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            ppit_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.store_pt = 1'b1;
                    if (kind && last_point)
                    begin
                        state_next = ppit_pkg::ST_START;
                    end
                end
            end
            ppit_pkg::ST_START:
            begin
                cmd.eval_init = 1'b1;
                state_next    = status.has_pairs ? ppit_pkg::ST_READ : ppit_pkg::ST_REPORT;
            end
            ppit_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ppit_pkg::ST_DIFF;
            end
            ppit_pkg::ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                op_next    = ppit_pkg::OP_X_PA;
                state_next = ppit_pkg::ST_ISSUE;
            end
            ppit_pkg::ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (op_reg == ppit_pkg::OP_D2_QB)
                begin
                    state_next = ppit_pkg::ST_DRAIN;
                end
                else
                begin
                    op_next = ppit_pkg::op_t'(op_reg + 4'd1);
                end
            end
            ppit_pkg::ST_DRAIN:
            begin
                // last product term lands in the sign flags here
                state_next = ppit_pkg::ST_DECIDE;
            end
            ppit_pkg::ST_DECIDE:
            begin
                if (status.meet)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = ppit_pkg::ST_REPORT;
                end
                else if (status.last_pair)
                begin
                    state_next = ppit_pkg::ST_REPORT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ppit_pkg::ST_READ;
                end
            end
            ppit_pkg::ST_REPORT:
            begin
                cmd.clear  = 1'b1;
                state_next = ppit_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ppit_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ppit_pkg::ST_IDLE);
    assign done = (state_reg == ppit_pkg::ST_REPORT);

endmodule

// File: hw/rtl/polyline_pair_intersection_test_core.sv
// ----------------------------------------------------------------------------
// polyline_pair_intersection_test_core
// Loads two polylines point by point and reports whether any segment of the
// first touches or crosses any segment of the second.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy is low, one point per cycle
// while loading; points past MAX_POINTS per polyline are dropped and reported
// through overflow. The last point of the second polyline (kind 1 with
// last_point) starts the evaluation, the pair loop stopping at the first pair
// that meets. Each pair takes one memory read, one difference stage,
// 13 product terms through the shared two-multiplier unit, a drain state
// and a decide state. The result is on intersects and overflow for the
// single cycle in which done is high; the receiver cannot stall it and must
// take it then. Both stores empty afterward.
module polyline_pair_intersection_test_core #(
    parameter int MAX_POINTS = ppit_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = ppit_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         kind,
    input  logic signed [COORD_BITS-1:0] x_coord,
    input  logic signed [COORD_BITS-1:0] y_coord,
    input  logic                         last_point,
    output logic                         done,
    output logic                         intersects,
    output logic                         overflow
);

    ppit_pkg::cmd_t    cmd;
    ppit_pkg::status_t status;

    ppit_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .last_point (last_point),
        .status     (status),
        .busy       (busy),
        .done       (done),
        .cmd        (cmd)
    );

    ppit_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .kind       (kind),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .intersects (intersects),
        .overflow   (overflow)
    );

endmodule
